// ===== src/dscb_pkg.sv =====
// shared types, constants and elaboration-time helpers for the crystal ball evaluator
// no dependencies; imported by dscb_ln, dscb_exp, the top level and the bench
`timescale 1ns / 1ps

package dscb_pkg;

  typedef enum logic [1:0] {
    REGION_CORE = 2'd0,
    REGION_LOW  = 2'd1,
    REGION_HIGH = 2'd2
  } region_t;

  typedef enum logic [2:0] {
    CFG_ALPHA_LOW  = 3'd0,
    CFG_ALPHA_HIGH = 3'd1,
    CFG_POWER_LOW  = 3'd2,
    CFG_POWER_HIGH = 3'd3,
    CFG_PEAK_MEAN  = 3'd4,
    CFG_PEAK_WIDTH = 3'd5,
    CFG_AMPLITUDE  = 3'd6
  } cfg_reg_t;

  localparam int Y_W   = 56;   // 1 + quotient of the tail division
  localparam int LG_W  = 22;   // log2 / ln in q16
  localparam int E_W   = 45;   // exponent in q16
  localparam int SHP_W = 33;   // shape in q32, 1.0 included

  localparam logic [31:0] LN2_Q32   = 32'd2977044472;
  localparam logic [32:0] LOG2E_Q32 = 33'd6196328019;

  // state carried next to the sigma division
  typedef struct packed {
    logic neg;
    logic ovf;
  } front_side_t;

  // state carried across the tail division and the log unit
  typedef struct packed {
    region_t      region;
    logic [44:0]  core_e;
    logic [30:0]  aa;
  } tail_side_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] rem;
    logic [63:0] res;
    logic [63:0] bitv;
    rem  = v;
    res  = '0;
    bitv = 64'h4000_0000_0000_0000;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2^(-2^-(k+1)) in q0.32, by repeated floor square roots
  function automatic logic [31:0] exp_root(input int k);
    logic [63:0] r;
    r = 64'h8000_0000;
    for (int i = 0; i <= k; i++) begin
      r = isqrt64(r << 32);
    end
    return r[31:0];
  endfunction

endpackage

// ===== src/dscb_if.sv =====
// valid/ready channels for samples and results
// depends on nothing
`timescale 1ns / 1ps

interface dscb_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_x;
  modport source (output valid, output sample_x, input ready);
  modport sink   (input valid, input sample_x, output ready);
endinterface

interface dscb_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] value;
  logic [1:0]  region;
  logic        saturated;
  modport source (output valid, output value, output region, output saturated, input ready);
  modport sink   (input valid, input value, input region, input saturated, output ready);
endinterface

// ===== src/dscb_div.sv =====
// pipelined restoring divider, one quotient bit per stage
// standalone; sideband travels with each item
`timescale 1ns / 1ps

module dscb_div #(
  parameter int QW     = 31,
  parameter int DVS_W  = 32,
  parameter int SIDE_W = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              v_in,
  input  logic [DVS_W-1:0]  rem_in,   // must be below the divisor
  input  logic [QW-1:0]     dvd_in,
  input  logic [DVS_W-1:0]  dvs_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              v_out,
  output logic [QW-1:0]     quo_out,
  output logic [SIDE_W-1:0] side_out
);

  logic              v   [QW+1];
  logic [DVS_W-1:0]  rem [QW+1];
  logic [QW-1:0]     dq  [QW+1];
  logic [DVS_W-1:0]  dvs [QW+1];
  logic [SIDE_W-1:0] sd  [QW+1];

  assign v[0]   = v_in;
  assign rem[0] = rem_in;
  assign dq[0]  = dvd_in;
  assign dvs[0] = dvs_in;
  assign sd[0]  = side_in;

  for (genvar i = 0; i < QW; i++) begin : g_stage
    logic [DVS_W:0]   r2;
    logic [DVS_W:0]   sub;
    logic             ge;
    logic [DVS_W-1:0] rem_next;
    logic [QW-1:0]    dq_next;

    always_comb begin
      r2       = {rem[i], dq[i][QW-1]};
      sub      = r2 - {1'b0, dvs[i]};
      ge       = r2 >= {1'b0, dvs[i]};
      rem_next = ge ? sub[DVS_W-1:0] : r2[DVS_W-1:0];
      dq_next  = {dq[i][QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i+1] <= 1'b0;
      end else if (en) begin
        v[i+1] <= v[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= rem_next;
        dq[i+1]  <= dq_next;
        dvs[i+1] <= dvs[i];
        sd[i+1]  <= sd[i];
      end
    end
  end

  assign v_out    = v[QW];
  assign quo_out  = dq[QW];
  assign side_out = sd[QW];

endmodule

// ===== src/dscb_ln.sv =====
// pipelined natural log in q16: leading one, normalize, 16 squaring steps, scale by ln 2
// uses dscb_pkg
`timescale 1ns / 1ps

module dscb_ln
  import dscb_pkg::*;
#(
  parameter int SIDE_W = 78
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              v_in,
  input  logic [Y_W-1:0]    y_in,     // at least 1.0
  input  logic [SIDE_W-1:0] side_in,
  output logic              v_out,
  output logic [LG_W-1:0]   ln_out,
  output logic [SIDE_W-1:0] side_out
);

  logic              va, vb, vd;
  logic [Y_W-1:0]    ya, yb;
  logic [5:0]        ka, kb;
  logic [SIDE_W-1:0] sa, sb, sdd;
  logic [LG_W-1:0]   lnv;

  logic              vc [17];
  logic [30:0]       mc [17];
  logic [LG_W-1:0]   lc [17];
  logic [SIDE_W-1:0] sc [17];

  logic [30:0]     m0;
  logic [LG_W-1:0] lg0;
  logic [53:0]     lnp;

  always_comb begin
    ka = '0;
    for (int b = 0; b < Y_W; b++) begin
      if (ya[b]) ka = 6'(b);
    end
  end

  always_comb begin
    if (kb >= 6'd30) m0 = 31'(yb >> (kb - 6'd30));
    else             m0 = 31'(yb << (6'd30 - kb));
    lg0 = {kb - 6'd16, 16'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      va    <= 1'b0;
      vb    <= 1'b0;
      vc[0] <= 1'b0;
    end else if (en) begin
      va    <= v_in;
      vb    <= va;
      vc[0] <= vb;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ya    <= y_in;
      sa    <= side_in;
      yb    <= ya;
      kb    <= ka;
      sb    <= sa;
      mc[0] <= m0;
      lc[0] <= lg0;
      sc[0] <= sb;
    end
  end

  for (genvar i = 0; i < 16; i++) begin : g_sq
    logic [61:0]     sq;
    logic [31:0]     t;
    logic [30:0]     m_next;
    logic [LG_W-1:0] l_next;

    always_comb begin
      sq     = {31'b0, mc[i]} * {31'b0, mc[i]};
      t      = sq[61:30];
      l_next = lc[i];
      if (t[31]) begin
        m_next         = t[31:1];
        l_next[15 - i] = 1'b1;
      end else begin
        m_next = t[30:0];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vc[i+1] <= 1'b0;
      end else if (en) begin
        vc[i+1] <= vc[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        mc[i+1] <= m_next;
        lc[i+1] <= l_next;
        sc[i+1] <= sc[i];
      end
    end
  end

  assign lnp = 54'(lc[16]) * 54'(LN2_Q32);

  always_ff @(posedge clk) begin
    if (rst) begin
      vd <= 1'b0;
    end else if (en) begin
      vd <= vc[16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lnv <= lnp[53:32];
      sdd <= sc[16];
    end
  end

  assign v_out    = vd;
  assign ln_out   = lnv;
  assign side_out = sdd;

endmodule

// ===== src/dscb_exp.sv =====
// pipelined exp(-e) in q32: scale by log2 e, 16 root multiplies, final right shift
// uses dscb_pkg
`timescale 1ns / 1ps

module dscb_exp
  import dscb_pkg::*;
#(
  parameter int SIDE_W = 2
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              v_in,
  input  logic [E_W-1:0]    e_in,
  input  logic [SIDE_W-1:0] side_in,
  output logic              v_out,
  output logic [SHP_W-1:0]  shape_out,
  output logic [SIDE_W-1:0] side_out
);

  logic              va, vf;
  logic [E_W-1:0]    ea;
  logic [SIDE_W-1:0] sa, sf;
  logic [SHP_W-1:0]  shp;

  logic              vp [17];
  logic [SHP_W-1:0]  pp [17];
  logic [22:0]       wp [17];
  logic              zp [17];
  logic [SIDE_W-1:0] sp [17];

  logic [54:0]      wprod;
  logic             zero_a;
  logic [6:0]       ip;
  logic [SHP_W-1:0] shp_next;

  assign wprod  = 55'(ea[21:0]) * 55'(LOG2E_Q32);
  assign zero_a = |ea[E_W-1:22];

  always_ff @(posedge clk) begin
    if (rst) begin
      va    <= 1'b0;
      vp[0] <= 1'b0;
    end else if (en) begin
      va    <= v_in;
      vp[0] <= va;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ea    <= e_in;
      sa    <= side_in;
      pp[0] <= {1'b1, 32'b0};
      wp[0] <= wprod[54:32];
      zp[0] <= zero_a;
      sp[0] <= sa;
    end
  end

  for (genvar j = 0; j < 16; j++) begin : g_root
    localparam logic [31:0] ROOT = exp_root(j);
    logic [64:0]      prod;
    logic [SHP_W-1:0] p_next;

    always_comb begin
      prod   = 65'(pp[j]) * 65'(ROOT);
      p_next = wp[j][15 - j] ? prod[64:32] : pp[j];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        vp[j+1] <= 1'b0;
      end else if (en) begin
        vp[j+1] <= vp[j];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        pp[j+1] <= p_next;
        wp[j+1] <= wp[j];
        zp[j+1] <= zp[j];
        sp[j+1] <= sp[j];
      end
    end
  end

  always_comb begin
    ip = wp[16][22:16];
    if (zp[16] || ip >= 7'd63) shp_next = '0;
    else                       shp_next = pp[16] >> ip;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vf <= 1'b0;
    end else if (en) begin
      vf <= vp[16];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      shp <= shp_next;
      sf  <= sp[16];
    end
  end

  assign v_out     = vf;
  assign shape_out = shp;
  assign side_out  = sf;

endmodule

// ===== src/double_sided_crystal_ball_eval_unit.sv =====
// top level of the double-sided crystal ball evaluator: registers, front end, tail prep, scaling
// uses dscb_pkg, dscb_if, dscb_div, dscb_ln, dscb_exp
`timescale 1ns / 1ps

// usage
//   sample_ch takes one signed q16.16 abscissa per transfer; result_ch returns one
//   transfer per sample: value (unsigned q24.8), region (0 core, 1 low tail,
//   2 high tail) and saturated, in sample order
//   the seven shape registers are written through cfg_we / cfg_index / cfg_data
//   while the pipeline is empty; indexes with no register are ignored
//   one sample per cycle is taken while the pipeline is not held; the depth is
//   set by the two bit-per-stage dividers (31 and 55 stages), the
//   16 squaring steps of the log unit and the 16 root multiplies of the exp unit
//   all stages advance together: when the result register is full and the
//   receiver holds ready low, the whole pipeline holds and sample_ch.ready
//   drops, so nothing is lost or repeated; otherwise ready stays high
//   reset clears all valid bits and loads the default shape settings
//   no clearing pass or warm-up is needed after reset

module double_sided_crystal_ball_eval_unit
  import dscb_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  dscb_in_if.sink     sample_ch,
  dscb_out_if.source  result_ch,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int TAIL_SIDE_W = $bits(tail_side_t);

  // shape registers
  logic [23:0] alpha_low, alpha_high, power_low, power_high;
  logic [31:0] peak_mean, peak_width, amplitude;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha_low  <= 24'd81920;
      alpha_high <= 24'd94372;
      power_low  <= 24'd104202;
      power_high <= 24'd117965;
      peak_mean  <= 32'd5976883;
      peak_width <= 32'd131072;
      amplitude  <= 32'd256;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_ALPHA_LOW:  alpha_low  <= cfg_data[23:0];
        CFG_ALPHA_HIGH: alpha_high <= cfg_data[23:0];
        CFG_POWER_LOW:  power_low  <= cfg_data[23:0];
        CFG_POWER_HIGH: power_high <= cfg_data[23:0];
        CFG_PEAK_MEAN:  peak_mean  <= cfg_data;
        CFG_PEAK_WIDTH: peak_width <= cfg_data;
        CFG_AMPLITUDE:  amplitude  <= cfg_data;
        default: ;
      endcase
    end
  end

  // zero width or power acts as the smallest step
  logic [31:0] sigma;
  logic [23:0] n_low, n_high;
  assign sigma  = (peak_width == '0) ? 32'd1 : peak_width;
  assign n_low  = (power_low  == '0) ? 24'd1 : power_low;
  assign n_high = (power_high == '0) ? 24'd1 : power_high;

  // single stall signal for every stage
  logic en;
  logic t7_valid;
  assign en              = !t7_valid || result_ch.ready;
  assign sample_ch.ready = en;

  // s0: input register
  logic        s0_valid;
  logic [31:0] s0_x;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= sample_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_x <= sample_ch.sample_x;
    end
  end

  // s1: distance from the mean, clamp check for |t| >= 2^31 in q16.16
  logic [32:0]  diff, mag;
  logic [48:0]  dvd_full;
  logic         ovf_c;
  logic         s1_valid;
  front_side_t  s1_side;
  logic [31:0]  s1_rem;
  logic [30:0]  s1_dvd;

  always_comb begin
    diff     = {s0_x[31], s0_x} - {peak_mean[31], peak_mean};
    mag      = diff[32] ? (33'd0 - diff) : diff;
    dvd_full = {mag, 16'b0};
    ovf_c    = {14'b0, dvd_full} >= {sigma, 31'b0};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= s0_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_side.neg <= diff[32];
      s1_side.ovf <= ovf_c;
      s1_rem      <= ovf_c ? 32'd0 : {14'b0, dvd_full[48:31]};
      s1_dvd      <= dvd_full[30:0];
    end
  end

  // |t| = |x - mean| / sigma
  logic        d1_valid;
  logic [30:0] d1_quo;
  logic [1:0]  d1_side_raw;
  front_side_t d1_side;

  dscb_div #(
    .QW     (31),
    .DVS_W  (32),
    .SIDE_W ($bits(front_side_t))
  ) u_div_t (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .v_in     (s1_valid),
    .rem_in   (s1_rem),
    .dvd_in   (s1_dvd),
    .dvs_in   (sigma),
    .side_in  (s1_side),
    .v_out    (d1_valid),
    .quo_out  (d1_quo),
    .side_out (d1_side_raw)
  );

  assign d1_side = d1_side_raw;

  // t1: region select and distance past the transition point
  logic [30:0] tm;
  region_t     region_c;
  logic [30:0] d_c;
  logic        t1_valid;
  logic [30:0] t1_tm, t1_d;
  region_t     t1_region;

  always_comb begin
    tm = d1_side.ovf ? 31'h7FFF_FFFF : d1_quo;
    priority if (d1_side.neg && tm > 31'(alpha_low)) begin
      region_c = REGION_LOW;
      d_c      = tm - 31'(alpha_low);
    end else if (!d1_side.neg && tm > 31'(alpha_high)) begin
      region_c = REGION_HIGH;
      d_c      = tm - 31'(alpha_high);
    end else begin
      region_c = REGION_CORE;
      d_c      = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_valid <= 1'b0;
    end else if (en) begin
      t1_valid <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_tm     <= tm;
      t1_d      <= d_c;
      t1_region <= region_c;
    end
  end

  // t2: a*d for the tail ratio, t*t/2 for the core, a*a/2 for the tail offset
  logic [23:0] a_t1, n_t1;
  logic [54:0] prod_ad;
  logic [61:0] tsq;
  logic [47:0] asq;
  logic        t2_valid;
  logic [54:0] t2_prod;
  logic [23:0] t2_n;
  tail_side_t  t2_side;

  always_comb begin
    a_t1    = (t1_region == REGION_LOW) ? alpha_low : alpha_high;
    n_t1    = (t1_region == REGION_LOW) ? n_low : n_high;
    prod_ad = 55'(a_t1) * 55'(t1_d);
    tsq     = 62'(t1_tm) * 62'(t1_tm);
    asq     = 48'(a_t1) * 48'(a_t1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t2_valid <= 1'b0;
    end else if (en) begin
      t2_valid <= t1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t2_prod        <= prod_ad;
      t2_n           <= n_t1;
      t2_side.region <= t1_region;
      t2_side.core_e <= tsq[61:17];
      t2_side.aa     <= asq[47:17];
    end
  end

  // q = a*d / n
  logic                   d2_valid;
  logic [54:0]            d2_quo;
  logic [TAIL_SIDE_W-1:0] d2_side;

  dscb_div #(
    .QW     (55),
    .DVS_W  (24),
    .SIDE_W (TAIL_SIDE_W)
  ) u_div_q (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .v_in     (t2_valid),
    .rem_in   (24'd0),
    .dvd_in   (t2_prod),
    .dvs_in   (t2_n),
    .side_in  (t2_side),
    .v_out    (d2_valid),
    .quo_out  (d2_quo),
    .side_out (d2_side)
  );

  // t3: y = 1 + q in q16
  logic                   t3_valid;
  logic [Y_W-1:0]         t3_y;
  logic [TAIL_SIDE_W-1:0] t3_side;

  always_ff @(posedge clk) begin
    if (rst) begin
      t3_valid <= 1'b0;
    end else if (en) begin
      t3_valid <= d2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t3_y    <= 56'd65536 + {1'b0, d2_quo};
      t3_side <= d2_side;
    end
  end

  logic                   l_valid;
  logic [LG_W-1:0]        l_ln;
  logic [TAIL_SIDE_W-1:0] l_side_raw;
  tail_side_t             l_side;

  dscb_ln #(
    .SIDE_W (TAIL_SIDE_W)
  ) u_ln (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .v_in     (t3_valid),
    .y_in     (t3_y),
    .side_in  (t3_side),
    .v_out    (l_valid),
    .ln_out   (l_ln),
    .side_out (l_side_raw)
  );

  assign l_side = l_side_raw;

  // t4: n * ln(y)
  logic [23:0] n_l;
  logic [45:0] nln_p;
  logic        t4_valid;
  logic [29:0] t4_nln;
  tail_side_t  t4_side;

  assign n_l   = (l_side.region == REGION_LOW) ? n_low : n_high;
  assign nln_p = 46'(n_l) * 46'(l_ln);

  always_ff @(posedge clk) begin
    if (rst) begin
      t4_valid <= 1'b0;
    end else if (en) begin
      t4_valid <= l_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t4_nln  <= nln_p[45:16];
      t4_side <= l_side;
    end
  end

  // t5: final exponent for the region
  logic [31:0]    tail_e;
  logic           t5_valid;
  logic [E_W-1:0] t5_e;
  region_t        t5_region;

  assign tail_e = 32'(t4_side.aa) + 32'(t4_nln);

  always_ff @(posedge clk) begin
    if (rst) begin
      t5_valid <= 1'b0;
    end else if (en) begin
      t5_valid <= t4_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t5_e      <= (t4_side.region == REGION_CORE) ? t4_side.core_e : 45'(tail_e);
      t5_region <= t4_side.region;
    end
  end

  logic             x_valid;
  logic [SHP_W-1:0] x_shape;
  logic [1:0]       x_side;

  dscb_exp #(
    .SIDE_W ($bits(region_t))
  ) u_exp (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .v_in      (t5_valid),
    .e_in      (t5_e),
    .side_in   (t5_region),
    .v_out     (x_valid),
    .shape_out (x_shape),
    .side_out  (x_side)
  );

  // t6: amplitude times shape
  logic        t6_valid;
  logic        t6_full;
  logic [63:0] t6_prod;
  region_t     t6_region;

  always_ff @(posedge clk) begin
    if (rst) begin
      t6_valid <= 1'b0;
    end else if (en) begin
      t6_valid <= x_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t6_full   <= x_shape[32];
      t6_prod   <= 64'(amplitude) * 64'(x_shape[31:0]);
      t6_region <= region_t'(x_side);
    end
  end

  // t7: round, clip, result register
  logic [64:0] rnd;
  logic [32:0] val;
  logic [31:0] t7_value;
  region_t     t7_region;
  logic        t7_sat;

  assign rnd = {1'b0, t6_prod} + 65'h0_8000_0000;
  assign val = t6_full ? {1'b0, amplitude} : rnd[64:32];

  always_ff @(posedge clk) begin
    if (rst) begin
      t7_valid <= 1'b0;
    end else if (en) begin
      t7_valid <= t6_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t7_value  <= val[32] ? 32'hFFFF_FFFF : val[31:0];
      t7_sat    <= val[32];
      t7_region <= t6_region;
    end
  end

  assign result_ch.valid     = t7_valid;
  assign result_ch.value     = t7_value;
  assign result_ch.region    = t7_region;
  assign result_ch.saturated = t7_sat;

`ifndef SYNTHESIS
  a_sat_full_scale: assert property (@(posedge clk) disable iff (rst)
    t7_valid && t7_sat |-> t7_value == 32'hFFFF_FFFF)
    else $error("saturated result not at full scale");

  a_tail_past_alpha: assert property (@(posedge clk) disable iff (rst)
    t1_valid && t1_region != REGION_CORE |-> t1_d != '0)
    else $error("tail region with no distance past alpha");

  a_core_no_dist: assert property (@(posedge clk) disable iff (rst)
    t1_valid && t1_region == REGION_CORE |-> t1_d == '0)
    else $error("core region carries a tail distance");

  a_full_shape: assert property (@(posedge clk) disable iff (rst)
    t6_valid && t6_full |-> t6_prod == '0)
    else $error("unit shape with nonzero fraction");
`endif

endmodule

// ===== dv/tb.sv =====
// self-checking bench for the double-sided crystal ball evaluator
// needs dscb_pkg, dscb_if and double_sided_crystal_ball_eval_unit from src
`timescale 1ns / 1ps

module tb;
  import dscb_pkg::*;

  typedef struct {
    logic [31:0] value;
    region_t     region;
    logic        saturated;
  } cb_result_t;

  // expected results plus a private copy of the shape registers
  class cb_scoreboard;
    logic [23:0] a_lo, a_hi, n_lo, n_hi;
    logic [31:0] mean, width, amp;
    logic [63:0] roots[16];
    cb_result_t  pending_q[$];
    int          errors;
    int          seen;
    int          region_hits[3];

    function new();
      logic [63:0] r;
      r = 64'h8000_0000;
      for (int k = 0; k < 16; k++) begin
        r = int_sqrt(r << 32);
        roots[k] = r;
      end
      load_defaults();
    endfunction

    function void load_defaults();
      a_lo = 24'd81920;  a_hi = 24'd94372;
      n_lo = 24'd104202; n_hi = 24'd117965;
      mean = 32'd5976883; width = 32'd131072; amp = 32'd256;
    endfunction

    function void write_reg(cfg_reg_t idx, logic [31:0] data);
      case (idx)
        CFG_ALPHA_LOW:  a_lo  = data[23:0];
        CFG_ALPHA_HIGH: a_hi  = data[23:0];
        CFG_POWER_LOW:  n_lo  = data[23:0];
        CFG_POWER_HIGH: n_hi  = data[23:0];
        CFG_PEAK_MEAN:  mean  = data;
        CFG_PEAK_WIDTH: width = data;
        CFG_AMPLITUDE:  amp   = data;
        default: ;
      endcase
    endfunction

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res, b;
      res = 0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v = v - (res + b);
          res = (res >> 1) + b;
        end else begin
          res = res >> 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    // natural log in q16 of a q16 argument >= 1.0
    function logic [63:0] ln_fix(logic [63:0] y);
      int k;
      logic [63:0] m, lg;
      k = 63;
      while (k > 0 && !y[k]) k--;
      m = (k >= 30) ? (y >> (k - 30)) : (y << (30 - k));
      lg = 64'(k - 16) << 16;
      for (int i = 15; i >= 0; i--) begin
        m = (m * m) >> 30;
        if (m >= 64'h8000_0000) begin
          m >>= 1;
          lg[i] = 1'b1;
        end
      end
      return (lg * 64'd2977044472) >> 32;
    endfunction

    // exp(-e) in q32 for e in q16
    function logic [63:0] exp_neg(logic [63:0] e);
      logic [63:0] w, ip, p;
      if (e >= 64'd4194304) return 0;
      w = (e * 64'd6196328019) >> 32;
      ip = w >> 16;
      p = 64'h1_0000_0000;
      for (int k = 0; k < 16; k++)
        if (w[15 - k]) p = (p * roots[k]) >> 32;
      if (ip >= 63) return 0;
      return p >> ip;
    endfunction

    function logic [63:0] tail_exp(logic [63:0] tm, logic [63:0] a, logic [63:0] n);
      logic [63:0] q;
      q = (a * (tm - a)) / n;
      return ((a * a) >> 17) + ((n * ln_fix(64'd65536 + q)) >> 16);
    endfunction

    function void note_sample(logic [31:0] x);
      longint      diff;
      logic [63:0] mag, sig, tm, e, shape, val;
      cb_result_t  r;
      diff = longint'(signed'(x)) - longint'(signed'(mean));
      mag = (diff < 0) ? 64'(-diff) : 64'(diff);
      sig = (width == 0) ? 64'd1 : 64'(width);
      tm = (mag << 16) / sig;
      if (tm > 64'h7FFF_FFFF) tm = 64'h7FFF_FFFF;
      if (diff < 0 && tm > a_lo) begin
        r.region = REGION_LOW;
        e = tail_exp(tm, a_lo, (n_lo == 0) ? 64'd1 : 64'(n_lo));
      end else if (diff >= 0 && tm > a_hi) begin
        r.region = REGION_HIGH;
        e = tail_exp(tm, a_hi, (n_hi == 0) ? 64'd1 : 64'(n_hi));
      end else begin
        r.region = REGION_CORE;
        e = (tm * tm) >> 17;
      end
      shape = exp_neg(e);
      if (shape >= 64'h1_0000_0000) val = amp;
      else val = (64'(amp) * shape + 64'h8000_0000) >> 32;
      r.saturated = 1'b0;
      if (val > 64'hFFFF_FFFF) begin
        val = 64'hFFFF_FFFF;
        r.saturated = 1'b1;
      end
      r.value = val[31:0];
      pending_q.push_back(r);
    endfunction

    function void check_result(logic [31:0] value, logic [1:0] region, logic saturated);
      cb_result_t r;
      seen++;
      if (pending_q.size() == 0) begin
        $error("unexpected result value=%h region=%0d", value, region);
        errors++;
        return;
      end
      r = pending_q.pop_front();
      if (region < 3) region_hits[region]++;
      if (value !== r.value) begin
        $error("value: expected %h, got %h", r.value, value);
        errors++;
      end
      if (region !== r.region) begin
        $error("region: expected %0d, got %0d", r.region, region);
        errors++;
      end
      if (saturated !== r.saturated) begin
        $error("saturated: expected %0b, got %0b", r.saturated, saturated);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          accepted = 0;

  dscb_in_if  sample_ch ();
  dscb_out_if result_ch ();

  cb_scoreboard sb = new();

  double_sided_crystal_ball_eval_unit dut (
    .clk      (clk),
    .rst      (rst),
    .sample_ch(sample_ch.sink),
    .result_ch(result_ch.source),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    sample_ch.valid = 1'b0;
    sample_ch.sample_x = '0;
    result_ch.ready = 1'b0;
  end

  // receiver back-pressure, changed on the falling edge
  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= stall_pct);
  end

  // check every result transfer at the rising edge
  always @(posedge clk) begin
    if (!rst && result_ch.valid && result_ch.ready)
      sb.check_result(result_ch.value, result_ch.region, result_ch.saturated);
  end

  // one register write while the pipeline is empty
  task automatic write_cfg(cfg_reg_t idx, logic [31:0] data);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = data;
    sb.write_reg(idx, data);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // offer one sample, idling first at random, until its transfer
  task automatic send_sample(logic [31:0] x);
    while ($urandom_range(99) < idle_pct) begin
      sample_ch.valid = 1'b0;
      @(negedge clk);
    end
    sample_ch.valid = 1'b1;
    sample_ch.sample_x = x;
    do @(posedge clk); while (!sample_ch.ready);
    sb.note_sample(x);
    accepted++;
    @(negedge clk);
  endtask

  // wait until every expected result is in, then for the pipeline depth
  task automatic drain();
    sample_ch.valid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  // random sample: mostly a few sigmas around the peak, sometimes anywhere
  function automatic logic [31:0] pick_sample();
    longint span, off;
    if ($urandom_range(9) == 0) return $urandom;
    span = longint'(sb.width) * $urandom_range(1, 12);
    if (span > 64'h1_0000_0000) span = 64'h1_0000_0000;
    off = longint'($urandom) % (span + 1);
    if ($urandom_range(1)) off = -off;
    return 32'(longint'(signed'(sb.mean)) + off);
  endfunction

  task automatic random_config(int style);
    case (style)
      0: begin
        // smallest legal settings
        write_cfg(CFG_ALPHA_LOW, 32'd1);
        write_cfg(CFG_ALPHA_HIGH, 32'd1);
        write_cfg(CFG_POWER_LOW, 32'd1);
        write_cfg(CFG_POWER_HIGH, 32'd1);
        write_cfg(CFG_PEAK_MEAN, 32'h8000_0000);
        write_cfg(CFG_PEAK_WIDTH, 32'd1);
        write_cfg(CFG_AMPLITUDE, 32'd0);
      end
      1: begin
        // largest legal settings
        write_cfg(CFG_ALPHA_LOW, 32'hFF_FFFF);
        write_cfg(CFG_ALPHA_HIGH, 32'hFF_FFFF);
        write_cfg(CFG_POWER_LOW, 32'hFF_FFFF);
        write_cfg(CFG_POWER_HIGH, 32'hFF_FFFF);
        write_cfg(CFG_PEAK_MEAN, 32'h7FFF_FFFF);
        write_cfg(CFG_PEAK_WIDTH, 32'hFFFF_FFFF);
        write_cfg(CFG_AMPLITUDE, 32'hFFFF_FFFF);
      end
      default: begin
        write_cfg(CFG_ALPHA_LOW, $urandom_range(1, 5 << 16));
        write_cfg(CFG_ALPHA_HIGH, $urandom_range(1, 5 << 16));
        write_cfg(CFG_POWER_LOW, $urandom_range(1, 20 << 16));
        write_cfg(CFG_POWER_HIGH, ($urandom_range(3) == 0) ? $urandom_range(1, 24'hFF_FFFF)
                                                           : $urandom_range(1, 20 << 16));
        write_cfg(CFG_PEAK_MEAN, $urandom);
        write_cfg(CFG_PEAK_WIDTH, ($urandom_range(3) == 0) ? $urandom | 32'd1
                                                           : $urandom_range(1, 32'h40_0000));
        write_cfg(CFG_AMPLITUDE, $urandom_range(1) ? $urandom : $urandom_range(0, 32'hFFFF));
      end
    endcase
  endtask

  initial begin
    logic [31:0] m;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed samples under the reset settings: peak, tail edges, field extremes
    m = sb.mean;
    send_sample(m);
    send_sample(m + 1);
    send_sample(m - 1);
    send_sample(m - 163840);          // exactly at the low transition
    send_sample(m - 163841);
    send_sample(m - 163839);
    send_sample(m + 188744);          // at the high transition
    send_sample(m + 188745);
    send_sample(m + 188743);
    send_sample(m - (20 << 16));      // deep low tail
    send_sample(m + (20 << 16));      // deep high tail
    send_sample(32'h8000_0000);       // most negative sample, huge t
    send_sample(32'h7FFF_FFFF);
    send_sample(32'h0000_0000);
    send_sample(32'hFFFF_FFFF);
    send_sample(32'hAAAA_AAAA);
    send_sample(32'h5555_5555);
    drain();
    write_cfg(CFG_AMPLITUDE, 32'hFFFF_FFFF);  // full scale at the peak
    write_cfg(cfg_reg_t'(3'd7), 32'h1234_5678);  // no such register, ignored
    send_sample(sb.mean);
    send_sample(sb.mean + 32'h0001_0000);
    drain();
    write_cfg(CFG_ALPHA_LOW, 32'd0);   // zero alpha: the core shrinks to t = 0
    write_cfg(CFG_ALPHA_HIGH, 32'd0);
    send_sample(sb.mean);
    send_sample(sb.mean - 1);
    send_sample(sb.mean + 1);
    drain();

    // random phases, idle pattern rotating through the four profiles
    for (int ph = 0; ph < 10; ph++) begin
      case (ph % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 57; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 57; end
        default: begin idle_pct = 36; stall_pct = 36; end
      endcase
      random_config(ph == 0 ? 0 : (ph == 5 ? 1 : 2));
      for (int i = 0; i < 83; i++) send_sample(pick_sample());
      drain();
    end
    idle_pct = 0;
    stall_pct = 0;

    $display("tb: %0d samples sent, %0d results checked (core %0d, low %0d, high %0d)",
             accepted, sb.seen, sb.region_hits[0], sb.region_hits[1], sb.region_hits[2]);
    $display("tb: shape settings covered reset values, both extremes and 8 random sets");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  // run limit
  initial begin
    #4ms;
    $display("tb: errors");
    $finish;
  end

endmodule
